// ----- rtl/fcc_pkg.sv -----
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared constants and types for the front coding codec.
// ----------------------------------------------------------------------------
package fcc_pkg;

   localparam int MAX_WORD_LEN = 32;
   localparam int ADDR_W       = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
   localparam int POS_W        = 6;
   localparam int MAX_RESULTS  = 32;

   localparam logic [7:0] BYTE_NEWLINE = 8'd10;
   localparam logic [7:0] ENC_TERM     = 8'd255;
   localparam logic [7:0] PLAIN_TERM   = 8'd0;

   typedef logic [1:0] phase_type;

   localparam phase_type PH_FIRST = 2'd0;
   localparam phase_type PH_START = 2'd1;
   localparam phase_type PH_WORD  = 2'd2;
   localparam phase_type PH_DONE  = 2'd3;

endpackage

// ----- rtl/front_coding_codec.sv -----
// ----------------------------------------------------------------------------
// front_coding_codec
// Shared-prefix coding of a sorted word list, one byte per request. Encode
// holds back bytes that match the stored word; decode replays the prefix
// from the word memory and then copies the suffix.
// ----------------------------------------------------------------------------
// Results: each result is registered from its request; a decode prefix
//   replay first reads the word memory into rd_data_ff, then registers it.
// Throughput: one request per cycle while the response slot is free and each
//   request gives one result at most; no request is taken while a match end
//   sends its held byte or a decode prefix replays over the one read port.
// Reset: synchronous; clears control state, the word memory is not cleared.
module front_coding_codec
   import fcc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,   // direction: 0 encode, 1 decode
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,     // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,     // [7:0] out_byte
   output logic       rsp_tlast,
   output logic [1:0] rsp_tuser      // [0] finished, [1] error
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_PEND   = 2'd1;
   localparam logic [1:0] ST_REPLAY = 2'd2;

   localparam logic [POS_W-1:0] MAX_LEN_P = POS_W'(MAX_WORD_LEN);
   localparam logic [7:0]       MAX_RES_B = 8'(MAX_RESULTS);

   logic [7:0]       word_mem [MAX_WORD_LEN];
   logic [7:0]       rd_data_ff;

   logic [1:0]       ctl_ff, ctl_in;
   logic             direction_ff;
   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] position_ff, position_in;
   logic [POS_W-1:0] stored_len_ff, stored_len_in;
   logic             matching_ff, matching_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_fin_ff, rsp_fin_in;
   logic             rsp_err_ff, rsp_err_in;

   logic [7:0]       pend_byte_ff, pend_byte_in;
   logic             pend_err_ff, pend_err_in;
   logic [POS_W-1:0] rep_idx_ff, rep_idx_in;
   logic [POS_W-1:0] rep_cnt_ff, rep_cnt_in;
   logic             rep_err_ff, rep_err_in;

   logic              accept, slot_free;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr, rep_addr;
   logic              rep_rd;
   logic [7:0]        b;
   logic              wb_nl, wb_store, wb_err;
   logic              eff_match, hit;
   logic              over, last_rep;
   logic [7:0]        cnt_a;
   logic [POS_W-1:0]  cnt;
   logic              cnt_err;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (ctl_ff == ST_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;

   // ordinary word byte handling
   assign wb_nl    = (b == BYTE_NEWLINE);
   assign wb_store = !wb_nl && (position_ff < MAX_LEN_P);
   assign wb_err   = !wb_nl && !wb_store;

   assign eff_match = (phase_ff == PH_START) ? 1'b1 : matching_ff;
   assign hit = eff_match && !wb_nl && (position_ff < stored_len_ff)
                && (position_ff < MAX_LEN_P) && (rd_data_ff == b);

   // decode prefix count, clamped to the stored length and the result limit
   assign over    = (b > {2'b00, stored_len_ff});
   assign cnt_a   = over ? {2'b00, stored_len_ff} : b;
   assign cnt     = (cnt_a > MAX_RES_B) ? POS_W'(MAX_RESULTS) : cnt_a[POS_W-1:0];
   assign cnt_err = over || (cnt_a > MAX_RES_B);

   assign last_rep = ((rep_idx_ff + 1'b1) == rep_cnt_ff);

   always_comb begin
      ctl_in        = ctl_ff;
      phase_in      = phase_ff;
      position_in   = position_ff;
      stored_len_in = stored_len_ff;
      matching_in   = matching_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_fin_in    = rsp_fin_ff;
      rsp_err_in    = rsp_err_ff;
      pend_byte_in  = pend_byte_ff;
      pend_err_in   = pend_err_ff;
      rep_idx_in    = rep_idx_ff;
      rep_cnt_in    = rep_cnt_ff;
      rep_err_in    = rep_err_ff;
      wr_en         = 1'b0;
      wr_addr       = position_ff[ADDR_W-1:0];
      rep_rd        = 1'b0;
      rep_addr      = rep_idx_ff[ADDR_W-1:0];

      case (ctl_ff)
         ST_IDLE: begin
            if (accept) begin
               case (phase_ff)
                  PH_DONE: begin
                  end
                  PH_FIRST: begin
                     if (wb_nl) begin
                        stored_len_in = position_ff;
                        position_in   = '0;
                        phase_in      = PH_START;
                     end else if (wb_store) begin
                        wr_en       = 1'b1;
                        position_in = position_ff + 1'b1;
                     end
                     rsp_valid_in = 1'b1;
                     rsp_byte_in  = b;
                     rsp_last_in  = 1'b1;
                     rsp_fin_in   = 1'b0;
                     rsp_err_in   = wb_err;
                  end
                  default: begin
                     if (!direction_ff) begin
                        if (phase_ff == PH_START && b == PLAIN_TERM) begin
                           phase_in     = PH_DONE;
                           rsp_valid_in = 1'b1;
                           rsp_byte_in  = ENC_TERM;
                           rsp_last_in  = 1'b1;
                           rsp_fin_in   = 1'b1;
                           rsp_err_in   = 1'b0;
                        end else begin
                           if (phase_ff == PH_START) begin
                              phase_in    = PH_WORD;
                              matching_in = 1'b1;
                           end
                           if (hit) begin
                              position_in = position_ff + 1'b1;
                           end else begin
                              if (wb_nl) begin
                                 stored_len_in = position_ff;
                                 position_in   = '0;
                                 phase_in      = PH_START;
                              end else if (wb_store) begin
                                 wr_en       = 1'b1;
                                 position_in = position_ff + 1'b1;
                              end
                              rsp_valid_in = 1'b1;
                              rsp_fin_in   = 1'b0;
                              rsp_err_in   = wb_err;
                              if (eff_match) begin
                                 // match ends: count first, byte held for next slot
                                 matching_in  = 1'b0;
                                 rsp_byte_in  = {2'b00, position_ff};
                                 rsp_last_in  = 1'b0;
                                 pend_byte_in = b;
                                 pend_err_in  = wb_err;
                                 ctl_in       = ST_PEND;
                              end else begin
                                 rsp_byte_in = b;
                                 rsp_last_in = 1'b1;
                              end
                           end
                        end
                     end else if (phase_ff == PH_START) begin
                        if (b == ENC_TERM) begin
                           phase_in     = PH_DONE;
                           rsp_valid_in = 1'b1;
                           rsp_byte_in  = PLAIN_TERM;
                           rsp_last_in  = 1'b1;
                           rsp_fin_in   = 1'b1;
                           rsp_err_in   = 1'b0;
                        end else begin
                           position_in = cnt;
                           phase_in    = PH_WORD;
                           if (cnt != '0) begin
                              ctl_in     = ST_REPLAY;
                              rep_idx_in = '0;
                              rep_cnt_in = cnt;
                              rep_err_in = cnt_err;
                              rep_rd     = 1'b1;
                              rep_addr   = '0;
                           end
                        end
                     end else begin
                        if (wb_nl) begin
                           stored_len_in = position_ff;
                           position_in   = '0;
                           phase_in      = PH_START;
                        end else if (wb_store) begin
                           wr_en       = 1'b1;
                           position_in = position_ff + 1'b1;
                        end
                        rsp_valid_in = 1'b1;
                        rsp_byte_in  = b;
                        rsp_last_in  = 1'b1;
                        rsp_fin_in   = 1'b0;
                        rsp_err_in   = wb_err;
                     end
                  end
               endcase
            end
         end
         ST_PEND: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = pend_byte_ff;
               rsp_last_in  = 1'b1;
               rsp_fin_in   = 1'b0;
               rsp_err_in   = pend_err_ff;
               ctl_in       = ST_IDLE;
            end
         end
         ST_REPLAY: begin
            rep_rd = 1'b1;
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = rd_data_ff;
               rsp_last_in  = last_rep;
               rsp_fin_in   = 1'b0;
               rsp_err_in   = rep_err_ff;
               rep_idx_in   = rep_idx_ff + 1'b1;
               rep_addr     = rep_idx_in[ADDR_W-1:0];
               if (last_rep) begin
                  ctl_in = ST_IDLE;
               end
            end
         end
         default: begin
            ctl_in = ST_IDLE;
         end
      endcase

      // keep the entry at the next position ready for the match compare
      rd_addr = rep_rd ? rep_addr : position_in[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         word_mem[wr_addr] <= b;
      end
      rd_data_ff <= word_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff        <= ST_IDLE;
         direction_ff  <= 1'b0;
         phase_ff      <= PH_FIRST;
         position_ff   <= '0;
         stored_len_ff <= '0;
         matching_ff   <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         ctl_ff        <= ctl_in;
         phase_ff      <= phase_in;
         position_ff   <= position_in;
         stored_len_ff <= stored_len_in;
         matching_ff   <= matching_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            direction_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_fin_ff   <= rsp_fin_in;
      rsp_err_ff   <= rsp_err_in;
      pend_byte_ff <= pend_byte_in;
      pend_err_ff  <= pend_err_in;
      rep_idx_ff   <= rep_idx_in;
      rep_cnt_ff   <= rep_cnt_in;
      rep_err_ff   <= rep_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_err_ff, rsp_fin_ff};

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for front_coding_codec. A queue of bytes feeds a stream
// driver; every accepted request runs through a behavioral front coder that
// queues the bytes the block must return. A monitor pops and compares each
// response field by field. Encode and decode phases alternate through one
// stream that ends with the terminator. Both sides stall at random.
// ----------------------------------------------------------------------------
module testbench
   import fcc_pkg::*;
();

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       fin;
      logic       err;
   } coded_byte_type;

   logic       clock;
   logic       reset       = 1'b1;
   logic       csr_wr_en   = 1'b0;
   logic       csr_wr_data = 1'b0;
   logic       req_tvalid  = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata   = 8'd0;
   logic       rsp_tvalid;
   logic       rsp_tready  = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic [1:0] rsp_tuser;

   front_coding_codec u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // request bytes waiting for the driver, and responses still owed
   logic [7:0]     backlog[$];
   coded_byte_type expected_out[$];
   int             mismatches = 0;

   // behavioral front coder state
   logic [7:0] cw_word[MAX_WORD_LEN];
   logic [5:0] cw_len    = '0;
   logic [5:0] cw_pos    = '0;
   logic       cw_match  = 1'b1;
   phase_type  cw_phase  = PH_FIRST;
   logic       cw_decode = 1'b0;
   coded_byte_type step_out[$];
   logic       step_fault;

   // word as the block holds it, for shaping the next word
   logic [7:0] last_word[$];

   int  tx_gap  = 0;
   bit  tx_calm = 1'b0;
   int  hold_left = 0;
   bit  rx_calm = 1'b0;
   int  results_seen = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic emit(input logic [7:0] b, input logic fin);
      step_out.push_back('{data: b, last: 1'b0, fin: fin, err: 1'b0});
   endtask

   // plain word byte: newline closes the word, others stored until full
   task automatic take_word_byte(input logic [7:0] b);
      if (b == BYTE_NEWLINE) begin
         cw_len   = cw_pos;
         cw_pos   = '0;
         cw_phase = PH_START;
      end else if (cw_pos < MAX_WORD_LEN) begin
         cw_word[cw_pos[4:0]] = b;
         cw_pos++;
      end else begin
         step_fault = 1'b1;
      end
      emit(b, 1'b0);
   endtask

   task automatic front_code_byte(input logic [7:0] b);
      int cnt;
      step_out.delete();
      step_fault = 1'b0;
      case (cw_phase)
         PH_DONE: ;
         PH_FIRST: take_word_byte(b);
         default: begin
            if (!cw_decode) begin
               if (cw_phase == PH_START && b == PLAIN_TERM) begin
                  cw_phase = PH_DONE;
                  emit(ENC_TERM, 1'b1);
               end else begin
                  if (cw_phase == PH_START) begin
                     cw_phase = PH_WORD;
                     cw_pos   = '0;
                     cw_match = 1'b1;
                  end
                  // matched bytes are held back
                  if (cw_match && b != BYTE_NEWLINE && cw_pos < cw_len &&
                      cw_pos < MAX_WORD_LEN && cw_word[cw_pos[4:0]] == b) begin
                     cw_pos++;
                  end else begin
                     if (cw_match) begin
                        cw_match = 1'b0;
                        emit(8'(cw_pos), 1'b0);
                     end
                     take_word_byte(b);
                  end
               end
            end else if (cw_phase == PH_START) begin
               if (b == ENC_TERM) begin
                  cw_phase = PH_DONE;
                  emit(PLAIN_TERM, 1'b1);
               end else begin
                  cnt = b;
                  if (cnt > cw_len) begin
                     cnt = cw_len;
                     step_fault = 1'b1;
                  end
                  if (cnt > MAX_RESULTS) begin
                     cnt = MAX_RESULTS;
                     step_fault = 1'b1;
                  end
                  if (cnt > MAX_WORD_LEN)
                     cnt = MAX_WORD_LEN;
                  for (int k = 0; k < cnt; k++)
                     emit(cw_word[k], 1'b0);
                  cw_pos   = 6'(cnt);
                  cw_phase = PH_WORD;
               end
            end else begin
               take_word_byte(b);
            end
         end
      endcase
      foreach (step_out[k]) begin
         step_out[k].err  = step_fault;
         step_out[k].last = (k == step_out.size() - 1);
         expected_out.push_back(step_out[k]);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      logic fire;
      fire = req_tvalid && req_tready;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (fire)
            front_code_byte(req_tdata);
         if (!req_tvalid || fire) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_tvalid <= 1'b0;
            end else if (backlog.size() > 0) begin
               req_tdata  <= backlog.pop_front();
               req_tvalid <= 1'b1;
               if ($urandom_range(0, 39) == 0)
                  tx_calm = !tx_calm;
               tx_gap = tx_calm ? 0 : $urandom_range(0, 16);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin
      coded_byte_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_out.size() == 0) begin
               $display("%0t: unexpected response data %02h last %0b user %02b",
                        $time, rsp_tdata, rsp_tlast, rsp_tuser);
               mismatches++;
            end else begin
               want = expected_out.pop_front();
               if (rsp_tdata !== want.data) begin
                  $display("%0t: out_byte expected %02h actual %02h",
                           $time, want.data, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: last expected %0b actual %0b",
                           $time, want.last, rsp_tlast);
                  mismatches++;
               end
               if (rsp_tuser[0] !== want.fin) begin
                  $display("%0t: finished expected %0b actual %0b",
                           $time, want.fin, rsp_tuser[0]);
                  mismatches++;
               end
               if (rsp_tuser[1] !== want.err) begin
                  $display("%0t: error expected %0b actual %0b",
                           $time, want.err, rsp_tuser[1]);
                  mismatches++;
               end
            end
            results_seen++;
            // one long hold-off early on so the block backs up into the input
            if (results_seen == 40)
               hold_left = 300;
            else if ($urandom_range(0, 199) == 0)
               hold_left = $urandom_range(60, 200);
            else
               hold_left = rx_calm ? 0 : $urandom_range(0, 16);
            if ($urandom_range(0, 49) == 0)
               rx_calm = !rx_calm;
         end else if (hold_left > 0) begin
            hold_left--;
         end
         rsp_tready <= (hold_left == 0);
      end
   end

   function automatic logic [7:0] rand_word_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      return (b == BYTE_NEWLINE) ? 8'd11 : b;
   endfunction

   task automatic settle();
      do @(posedge clock);
      while (backlog.size() != 0 || req_tvalid || expected_out.size() != 0);
      // encode matches give no response, so let the pipe drain
      repeat (8) @(posedge clock);
   endtask

   task automatic set_direction(input logic v);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      cw_decode = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic queue_plain_word();
      logic [7:0] w[$];
      int keep;
      int total;
      keep  = $urandom_range(0, last_word.size());
      total = ($urandom_range(0, 11) == 0) ? $urandom_range(33, 40)
                                           : keep + $urandom_range(0, 5);
      for (int k = 0; k < total; k++)
         w.push_back((k < keep) ? last_word[k] : rand_word_byte());
      // a zero at word start would end the stream
      if (w.size() > 0 && w[0] == PLAIN_TERM)
         w[0] = 8'h01;
      foreach (w[k])
         backlog.push_back(w[k]);
      backlog.push_back(BYTE_NEWLINE);
      if (w.size() > MAX_WORD_LEN)
         w = w[0:MAX_WORD_LEN-1];
      last_word = w;
   endtask

   task automatic queue_coded_word();
      logic [7:0] w[$];
      logic [7:0] b;
      int cnt;
      int keep;
      int extra;
      // mostly valid counts, some above the stored length
      cnt   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 254)
                                          : $urandom_range(0, last_word.size());
      keep  = (cnt < last_word.size()) ? cnt : last_word.size();
      extra = ($urandom_range(0, 11) == 0) ? $urandom_range(33, 40) - keep
                                           : $urandom_range(0, 5);
      backlog.push_back(8'(cnt));
      for (int k = 0; k < keep; k++)
         w.push_back(last_word[k]);
      for (int k = 0; k < extra; k++) begin
         b = rand_word_byte();
         w.push_back(b);
         backlog.push_back(b);
      end
      backlog.push_back(BYTE_NEWLINE);
      if (w.size() > MAX_WORD_LEN)
         w = w[0:MAX_WORD_LEN-1];
      last_word = w;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      set_direction(1'b0);
      // first word with 0 and 255 passed through, then identical word,
      // prefix word, empty word, and 0/255 inside a word
      backlog = '{8'h41, 8'h00, 8'hFF, 8'h42, BYTE_NEWLINE,
                  8'h41, 8'h00, 8'hFF, 8'h42, BYTE_NEWLINE,
                  8'h41, 8'h00, BYTE_NEWLINE,
                  BYTE_NEWLINE,
                  8'h42, 8'hFF, 8'h00, BYTE_NEWLINE};

      set_direction(1'b1);
      // count above stored length, 255 inside a word, zero count
      backlog = '{8'd200, 8'h51, BYTE_NEWLINE,
                  8'd2, 8'hFF, BYTE_NEWLINE,
                  8'd0, 8'h00, BYTE_NEWLINE};
      last_word = '{8'h00};

      for (int p = 0; p < 8; p++) begin
         set_direction(p[0]);
         while (backlog.size() < 36) begin
            if (p[0])
               queue_coded_word();
            else
               queue_plain_word();
         end
      end

      // stream terminator, then bytes the block must ignore
      backlog.push_back(ENC_TERM);
      backlog.push_back(8'h00);
      backlog.push_back(8'h41);
      backlog.push_back(8'hFF);
      settle();
      repeat (20) @(posedge clock);

      if (mismatches == 0 && expected_out.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
